// ===== rtl/counting_semaphore_table_defines.svh =====
// ----------------------------------------------------------------------------
// Semaphore table assertion macros
// Shared concurrent-assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_TABLE_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_DEFINES_SVH

// Same-cycle implication.
`define CSEM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("semaphore table check failed");

// Next-cycle implication.
`define CSEM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("semaphore table check failed");

`endif

// ===== rtl/csem_pkg.sv =====
// ----------------------------------------------------------------------------
// csem_pkg
// Sizes, command and action codes, control types and helpers shared by the
// semaphore table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package csem_pkg;

	// Table geometry
	localparam int NUM_SEMS  = 16;
	localparam int NUM_PROCS = 16;
	localparam int SEM_AW    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int PROC_AW   = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int QDEPTH    = NUM_SEMS * NUM_PROCS;
	localparam int QA_W      = $clog2(QDEPTH);

	// Field widths
	localparam int CMD_W = 2;
	localparam int PID_W = 4;
	localparam int SID_W = 4;
	localparam int CNT_W = 16;
	localparam int ACT_W = 3;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SIGNAL = 2'd2;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FULL    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_BLOCK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_UNBLOCK = 3'd4;
	localparam logic [ACT_W-1:0] ACT_INVALID = 3'd5;

	// Count limits
	localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
	localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} st_t;

	// Claim request into the valid table
	typedef struct packed {
		logic              set;
		logic [SEM_AW-1:0] idx;
	} vld_set_t;

	// Valid table status
	typedef struct packed {
		logic              full;
		logic [SEM_AW-1:0] free_idx;
		logic              hit;
	} vld_stat_t;

	// Ring slot after s, wrapping at NUM_PROCS
	function automatic logic [PROC_AW-1:0] slot_inc(input logic [PROC_AW-1:0] s);
		logic [PROC_AW-1:0] r;
		if (s == PROC_AW'(NUM_PROCS - 1))
			r = '0;
		else
			r = s + 1'b1;
		return r;
	endfunction

	// Flat wait-queue address of one ring slot
	function automatic logic [QA_W-1:0] qaddr(input logic [SEM_AW-1:0] sem,
			input logic [PROC_AW-1:0] slot);
		logic [QA_W-1:0] r;
		r = QA_W'(sem) * QA_W'(NUM_PROCS) + QA_W'(slot);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/csem_ram.sv =====
// ----------------------------------------------------------------------------
// csem_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/csem_valid.sv =====
// ----------------------------------------------------------------------------
// csem_valid
// Entry valid bits: lookup of one entry, lowest-free search and claim.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_valid (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire csem_pkg::vld_set_t            set_req,
	input  wire logic [csem_pkg::SEM_AW-1:0]   lk_idx,
	output csem_pkg::vld_stat_t                stat
);
	import csem_pkg::*;

	logic [NUM_SEMS-1:0] valid_q;
	logic [SEM_AW-1:0]   free_idx;

	// Mark claimed entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (set_req.set)
			valid_q[set_req.idx] <= 1'b1;
	end

	// Find the lowest free entry
	always_comb begin
		free_idx = '0;
		for (int i = NUM_SEMS - 1; i >= 0; i--) begin
			if (!valid_q[i])
				free_idx = SEM_AW'(i);
		end
	end

	assign stat.full     = &valid_q;
	assign stat.free_idx = free_idx;
	assign stat.hit      = valid_q[lk_idx];

endmodule

`default_nettype wire

// ===== rtl/counting_semaphore_table.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores with a FIFO ring of waiters per entry.
// ----------------------------------------------------------------------------
//  channel  | handshake         | word
//  ---------+-------------------+-----------------------------------------------
//  command  | start, busy       | command, process_id, sem_id, init_value
//  result   | done (one cycle)  | action, result_sem_id, result_process
//
//  A command is taken when start is high and busy is low. The count RAM and
//  the wait-queue RAM are read in the accept cycle, and the update is
//  computed and written back in the next one, with busy high.
//  The result appears with done in the cycle after that, while the next
//  command may already be taken. Reset clears the valid bits and the ring
//  pointers at once; no clearing pass is needed. done cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [csem_pkg::CMD_W-1:0]    command,
	input  wire logic [csem_pkg::PID_W-1:0]    process_id,
	input  wire logic [csem_pkg::SID_W-1:0]    sem_id,
	input  wire logic signed [csem_pkg::CNT_W-1:0] init_value,
	output logic                               done,
	output logic      [csem_pkg::ACT_W-1:0]    action,
	output logic      [csem_pkg::SID_W-1:0]    result_sem_id,
	output logic      [csem_pkg::PID_W-1:0]    result_process
);
	import csem_pkg::*;

	st_t state_q, state_nx;
	logic exec_en;
	logic acc;

	// Ring pointers and wrap marks per entry
	logic [PROC_AW-1:0] head_q [NUM_SEMS];
	logic [PROC_AW-1:0] tail_q [NUM_SEMS];
	logic [NUM_SEMS-1:0] wrap_q;

	// Command captured at accept
	logic [CMD_W-1:0]        cmd_s1;
	logic [PID_W-1:0]        pid_s1;
	logic [SEM_AW-1:0]       sidx_s1;
	logic signed [CNT_W-1:0] init_s1;
	logic                    ok_s1;
	logic [PROC_AW-1:0]      head_s1;
	logic [PROC_AW-1:0]      tail_s1;
	logic                    wrap_s1;

	logic [SEM_AW-1:0] sid_idx;
	logic              in_range;

	// Valid table
	vld_set_t  set_req;
	vld_stat_t vstat;

	// Memory ports
	logic                    cnt_we;
	logic [SEM_AW-1:0]       cnt_waddr;
	logic signed [CNT_W-1:0] cnt_wdata;
	logic [CNT_W-1:0]        cnt_rdata;
	logic                    q_we;
	logic [PID_W-1:0]        q_rdata;

	// Update decisions
	logic signed [CNT_W-1:0] cnt;
	logic signed [CNT_W-1:0] cnt_dec;
	logic signed [CNT_W-1:0] cnt_inc;
	logic                    q_written;
	logic                    tail_adv;
	logic                    head_adv;
	logic [ACT_W-1:0]        act_nx;
	logic [SID_W-1:0]        rsem_nx;
	logic [PID_W-1:0]        rproc_nx;

	assign acc      = start & ~busy;
	assign sid_idx  = SEM_AW'(sem_id);
	assign in_range = (32'(sem_id) < 32'(NUM_SEMS));

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc)
					state_nx = ST_EXEC;
			end
			ST_EXEC: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		busy    = 1'b0;
		exec_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy    = 1'b0;
				exec_en = 1'b0;
			end
			ST_EXEC: begin
				busy    = 1'b1;
				exec_en = 1'b1;
			end
			default: begin
				busy    = 1'b0;
				exec_en = 1'b0;
			end
		endcase
	end

	csem_valid u_valid (
		.clk     (clk),
		.arst_n  (arst_n),
		.set_req (set_req),
		.lk_idx  (sid_idx),
		.stat    (vstat)
	);

	// Hold the command word and the entry's pointers
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1  <= command;
			pid_s1  <= process_id;
			sidx_s1 <= sid_idx;
			init_s1 <= init_value;
			ok_s1   <= in_range & vstat.hit;
			head_s1 <= head_q[sid_idx];
			tail_s1 <= tail_q[sid_idx];
			wrap_s1 <= wrap_q[sid_idx];
		end
	end

	csem_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_SEMS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (sid_idx),
		.rdata (cnt_rdata)
	);

	csem_ram #(
		.WIDTH (PID_W),
		.DEPTH (QDEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (qaddr(sidx_s1, tail_s1)),
		.wdata (pid_s1),
		.raddr (qaddr(sid_idx, head_q[sid_idx])),
		.rdata (q_rdata)
	);

	// Saturating count steps
	assign cnt     = cnt_rdata;
	assign cnt_dec = (cnt != CNT_MIN) ? cnt - 16'sd1 : cnt;
	assign cnt_inc = (cnt != CNT_MAX) ? cnt + 16'sd1 : cnt;

	// A slot never written reads as zero
	assign q_written = wrap_s1 | (head_s1 < tail_s1);

	// Decide the update and the result
	always_comb begin
		act_nx      = ACT_NONE;
		rsem_nx     = '0;
		rproc_nx    = '0;
		cnt_we      = 1'b0;
		cnt_waddr   = sidx_s1;
		cnt_wdata   = cnt;
		q_we        = 1'b0;
		tail_adv    = 1'b0;
		head_adv    = 1'b0;
		set_req.set = 1'b0;
		set_req.idx = vstat.free_idx;
		if (exec_en) begin
			case (cmd_s1)
				CMD_ALLOC: begin
					if (vstat.full) begin
						act_nx = ACT_FULL;
					end else begin
						act_nx      = ACT_ALLOC;
						rsem_nx     = SID_W'(vstat.free_idx);
						set_req.set = 1'b1;
						cnt_we      = 1'b1;
						cnt_waddr   = vstat.free_idx;
						cnt_wdata   = init_s1;
					end
				end
				CMD_WAIT: begin
					if (!ok_s1) begin
						act_nx = ACT_INVALID;
					end else begin
						cnt_we    = 1'b1;
						cnt_wdata = cnt_dec;
						if (cnt_dec < 16'sd0) begin
							act_nx   = ACT_BLOCK;
							rproc_nx = pid_s1;
							q_we     = 1'b1;
							tail_adv = 1'b1;
						end
					end
				end
				CMD_SIGNAL: begin
					if (!ok_s1) begin
						act_nx = ACT_INVALID;
					end else begin
						cnt_we    = 1'b1;
						cnt_wdata = cnt_inc;
						if (cnt_inc < 16'sd1) begin
							act_nx   = ACT_UNBLOCK;
							rproc_nx = q_written ? q_rdata : '0;
							head_adv = 1'b1;
						end
					end
				end
				default: act_nx = ACT_NONE;
			endcase
		end
	end

	// Advance ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEMS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			wrap_q <= '0;
		end else begin
			if (tail_adv) begin
				tail_q[sidx_s1] <= slot_inc(tail_s1);
				if (tail_s1 == PROC_AW'(NUM_PROCS - 1))
					wrap_q[sidx_s1] <= 1'b1;
			end
			if (head_adv)
				head_q[sidx_s1] <= slot_inc(head_s1);
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= exec_en;
	end

	// Result word
	always_ff @(posedge clk) begin
		if (exec_en) begin
			action         <= act_nx;
			result_sem_id  <= rsem_nx;
			result_process <= rproc_nx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/csem_checker.sv =====
// ----------------------------------------------------------------------------
// csem_checker
// Port-level timing and result checks for the semaphore table, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "counting_semaphore_table_defines.svh"

module csem_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic [csem_pkg::ACT_W-1:0]    action,
	input wire logic [csem_pkg::SID_W-1:0]    result_sem_id,
	input wire logic [csem_pkg::PID_W-1:0]    result_process
);
	import csem_pkg::*;

	// An accepted word locks the command side for its update cycle
	`CSEM_ASSERT_NXT(a_busy_after_acc, start && !busy, busy)
	// Each accepted word gives its result on done, registered from its update cycle
	`CSEM_ASSERT_IMP(a_done_latency, start && !busy, ##2 done)
	// A result only follows an update cycle
	`CSEM_ASSERT_IMP(a_done_after_busy, done, $past(busy) && !busy)
	// Only an allocation names a semaphore
	`CSEM_ASSERT_IMP(a_sem_id_zero, done && action != ACT_ALLOC, result_sem_id == 4'd0)
	// Only block and unblock name a process
	`CSEM_ASSERT_IMP(a_proc_zero, done && action != ACT_BLOCK && action != ACT_UNBLOCK,
		result_process == 4'd0)

endmodule

bind counting_semaphore_table csem_checker u_csem_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: semaphore table regression
// Sends allocate, wait and signal command words to counting_semaphore_table
// and checks every result word against a cycle-free model of the table. The
// model keeps its own valid bits, counts and waiter rings. A short directed
// run comes first, then random traffic focused on a few busy semaphores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import csem_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam int RANDOM_WORDS = 1950;

	typedef struct {
		logic [CMD_W-1:0]        cmd;
		logic [PID_W-1:0]        pid;
		logic [SID_W-1:0]        sid;
		logic signed [CNT_W-1:0] init;
		bit                      drain;
	} sem_cmd_t;

	typedef struct {
		logic [ACT_W-1:0] act;
		logic [SID_W-1:0] sem;
		logic [PID_W-1:0] proc;
	} sem_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [CMD_W-1:0] command = '0;
	logic [PID_W-1:0] process_id = '0;
	logic [SID_W-1:0] sem_id = '0;
	logic signed [CNT_W-1:0] init_value = '0;
	logic busy;
	logic done;
	logic [ACT_W-1:0] action;
	logic [SID_W-1:0] result_sem_id;
	logic [PID_W-1:0] result_process;

	// Model of the table
	bit                      sem_valid [NUM_SEMS];
	logic signed [CNT_W-1:0] sem_count [NUM_SEMS];
	logic [PID_W-1:0]        waiter_ring [NUM_SEMS][NUM_PROCS];
	logic [PROC_AW-1:0]      ring_head [NUM_SEMS];
	logic [PROC_AW-1:0]      ring_tail [NUM_SEMS];

	sem_cmd_t    pending_words [$];
	sem_result_t expected_results [$];
	sem_cmd_t    word_on_bus;
	int          words_sent = 0;
	int          total_words = 0;
	int          mismatches = 0;
	int          act_seen [8];
	int          gap_left = 0;
	int          burst_left = 0;
	bit          drained = 1'b1;

	counting_semaphore_table DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.process_id    (process_id),
		.sem_id        (sem_id),
		.init_value    (init_value),
		.done          (done),
		.action        (action),
		.result_sem_id (result_sem_id),
		.result_process(result_process)
	);

	always #6 clk = ~clk;

	// Apply one command to the model and return the result it must give
	function automatic sem_result_t sem_table_update(input sem_cmd_t c);
		sem_result_t r;
		int free_idx;
		r.act = ACT_NONE;
		r.sem = '0;
		r.proc = '0;
		free_idx = -1;
		if (c.cmd == CMD_ALLOC) begin
			for (int s = NUM_SEMS - 1; s >= 0; s--)
				if (!sem_valid[s])
					free_idx = s;
			if (free_idx < 0) begin
				r.act = ACT_FULL;
			end else begin
				sem_valid[free_idx] = 1'b1;
				sem_count[free_idx] = c.init;
				r.act = ACT_ALLOC;
				r.sem = SID_W'(free_idx);
			end
		end else if (c.cmd == CMD_WAIT || c.cmd == CMD_SIGNAL) begin
			if (int'(c.sid) >= NUM_SEMS || !sem_valid[c.sid]) begin
				r.act = ACT_INVALID;
			end else if (c.cmd == CMD_WAIT) begin
				// Saturate low, queue the caller while the count is negative
				if (sem_count[c.sid] > CNT_MIN)
					sem_count[c.sid] = sem_count[c.sid] - 1;
				if (sem_count[c.sid] < 0) begin
					waiter_ring[c.sid][ring_tail[c.sid]] = c.pid;
					ring_tail[c.sid] = PROC_AW'((int'(ring_tail[c.sid]) + 1) % NUM_PROCS);
					r.act = ACT_BLOCK;
					r.proc = c.pid;
				end
			end else begin
				// Saturate high, release the ring head while waiters remain
				if (sem_count[c.sid] < CNT_MAX)
					sem_count[c.sid] = sem_count[c.sid] + 1;
				if (sem_count[c.sid] < 1) begin
					r.proc = waiter_ring[c.sid][ring_head[c.sid]];
					ring_head[c.sid] = PROC_AW'((int'(ring_head[c.sid]) + 1) % NUM_PROCS);
					r.act = ACT_UNBLOCK;
				end
			end
		end
		return r;
	endfunction

	task automatic add_word(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid,
			input logic [SID_W-1:0] sid, input logic signed [CNT_W-1:0] init,
			input bit drain);
		sem_cmd_t w;
		w.cmd = cmd;
		w.pid = pid;
		w.sid = sid;
		w.init = init;
		w.drain = drain;
		pending_words.push_back(w);
	endtask

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	// Sender: bursts of words with random gaps, hold on drain requests
	always @(posedge clk) begin
		sem_cmd_t nxt;
		bit took;
		bit free_slot;
		if (arst_n) begin
			took = start && !busy;
			free_slot = !start || took;
			if (took) begin
				expected_results.push_back(sem_table_update(word_on_bus));
				words_sent++;
			end
			if (free_slot) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_words.size() != 0 &&
						(!pending_words[0].drain || (drained && !took))) begin
					nxt = pending_words.pop_front();
					word_on_bus = nxt;
					start <= 1'b1;
					command <= nxt.cmd;
					process_id <= nxt.pid;
					sem_id <= nxt.sid;
					init_value <= nxt.init;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// Keep a stretch without gaps in the middle of the random run
						if ((words_sent > 1000 && words_sent < 1300) || $urandom_range(0, 3) == 0)
							gap_left = 0;
						else
							gap_left = $urandom_range(1, 8);
						burst_left = $urandom_range(1, 24);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Let the sender see an empty expectation store without a same-edge race
	always @(negedge clk)
		drained <= (expected_results.size() == 0);

	// Receiver: compare each result word with the oldest expectation
	always @(posedge clk) begin
		sem_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				log_mismatch($sformatf("unexpected word: action %0d sem %0d proc %0d",
					action, result_sem_id, result_process));
			end else begin
				want = expected_results.pop_front();
				act_seen[want.act]++;
				if (action !== want.act || result_sem_id !== want.sem ||
						result_process !== want.proc)
					log_mismatch($sformatf(
						"mismatch: expected action %0d sem %0d proc %0d, got %0d %0d %0d",
						want.act, want.sem, want.proc,
						action, result_sem_id, result_process));
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [SID_W-1:0] hot [4];
		int wait_pct;
		int pick;
		int v;
		logic [CMD_W-1:0] cmd;
		logic [SID_W-1:0] sid;
		logic signed [CNT_W-1:0] init;

		for (int s = 0; s < NUM_SEMS; s++) begin
			sem_valid[s] = 1'b0;
			sem_count[s] = '0;
			ring_head[s] = '0;
			ring_tail[s] = '0;
			for (int p = 0; p < NUM_PROCS; p++)
				waiter_ring[s][p] = '0;
		end
		for (int a = 0; a < 8; a++)
			act_seen[a] = 0;

		// Directed: invalid ids, unknown command, count limits, ring underflow
		add_word(CMD_WAIT, 4'd1, 4'd0, 16'sh0000, 1'b0);
		add_word(CMD_SIGNAL, 4'd0, 4'd15, 16'sh1234, 1'b0);
		add_word(CMD_UNKNOWN, 4'd15, 4'd15, 16'shffff, 1'b0);
		add_word(CMD_ALLOC, 4'd0, 4'd0, CNT_MIN, 1'b0);
		add_word(CMD_WAIT, 4'd15, 4'd0, 16'sh0000, 1'b0);
		add_word(CMD_WAIT, 4'd9, 4'd0, 16'sh0000, 1'b0);
		add_word(CMD_SIGNAL, 4'd0, 4'd0, 16'sh0000, 1'b0);
		add_word(CMD_SIGNAL, 4'd0, 4'd0, 16'sh0000, 1'b0);
		add_word(CMD_SIGNAL, 4'd0, 4'd0, 16'sh0000, 1'b0);
		add_word(CMD_ALLOC, 4'd0, 4'd0, CNT_MAX, 1'b0);
		add_word(CMD_SIGNAL, 4'd7, 4'd1, 16'sh0000, 1'b0);
		add_word(CMD_WAIT, 4'd3, 4'd1, 16'sh0000, 1'b0);
		add_word(CMD_ALLOC, 4'd0, 4'd0, 16'sh0000, 1'b0);
		add_word(CMD_WAIT, 4'd5, 4'd2, 16'sh0000, 1'b0);
		add_word(CMD_SIGNAL, 4'd0, 4'd2, 16'sh0000, 1'b0);
		add_word(CMD_SIGNAL, 4'd0, 4'd2, 16'sh0000, 1'b0);
		add_word(CMD_ALLOC, 4'd0, 4'd0, 16'shffff, 1'b0);
		add_word(CMD_WAIT, 4'd0, 4'd3, 16'sh0000, 1'b0);
		add_word(CMD_WAIT, 4'd12, 4'd3, 16'sh0000, 1'b0);
		add_word(CMD_SIGNAL, 4'd0, 4'd3, 16'sh0000, 1'b0);
		add_word(CMD_WAIT, 4'd6, 4'd4, 16'sh0000, 1'b0);

		// Random: waits and signals mostly on a few busy semaphores
		wait_pct = 50;
		for (int a = 0; a < 4; a++)
			hot[a] = SID_W'(a);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 150 == 0) begin
				pick = $urandom_range(0, 2);
				wait_pct = (pick == 0) ? 20 : (pick == 1) ? 50 : 80;
				for (int a = 0; a < 4; a++)
					hot[a] = SID_W'($urandom_range(0, NUM_SEMS - 1));
			end
			init = CNT_W'($urandom);
			sid = SID_W'($urandom_range(0, 15));
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				cmd = CMD_ALLOC;
				if ($urandom_range(0, 7) != 0) begin
					v = int'($urandom_range(0, 5)) - 2;
					init = CNT_W'(v);
				end
			end else if (pick < 5) begin
				cmd = CMD_UNKNOWN;
			end else begin
				if (pick >= 15)
					sid = hot[$urandom_range(0, 3)];
				cmd = ($urandom_range(0, 99) < wait_pct) ? CMD_WAIT : CMD_SIGNAL;
			end
			add_word(cmd, PID_W'($urandom_range(0, 15)), sid, init, (i % 400) == 0);
		end
		total_words = pending_words.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (words_sent < total_words)
			@(posedge clk);
		for (int n = 0; n < 64 && expected_results.size() != 0; n++)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (expected_results.size() != 0)
			log_mismatch($sformatf("%0d expected words never arrived",
				expected_results.size()));

		$display("Sent %0d words: %0d allocated, %0d table full, %0d blocked, %0d unblocked,",
			words_sent, act_seen[ACT_ALLOC], act_seen[ACT_FULL], act_seen[ACT_BLOCK],
			act_seen[ACT_UNBLOCK]);
		$display("%0d ignored on invalid id, %0d with no action; %0d mismatches",
			act_seen[ACT_INVALID], act_seen[ACT_NONE], mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
